// ----- src/dwid_pkg.sv -----
// ----------------------------------------------------------------------------
// dwid_pkg
// Shared types and constants for the double-word integer divider.
// ----------------------------------------------------------------------------
package dwid_pkg;

    // Width of the operand and result ports, independent of DATA_WIDTH
    localparam int PORT_W = 64;

    // Division mode encoding on the cmd port
    localparam logic MODE_SIGNED   = 1'b0;
    localparam logic MODE_UNSIGNED = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture operands and prepare magnitudes
        logic step;     // one restoring subtract, one quotient bit
        logic finish;   // sign fix-up into the output register
    } dwid_ctl_t;

endpackage

// ----- src/dwid_dpath.sv -----
// ----------------------------------------------------------------------------
// dwid_dpath
// Operand preparation, radix-2 restoring division loop, sign fix-up and
// output register.
// ----------------------------------------------------------------------------
module dwid_dpath
    import dwid_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  dwid_ctl_t             ctl,
    input  logic                  mode,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_d,
    output logic [DATA_WIDTH-1:0] res_q,
    output logic [DATA_WIDTH-1:0] res_r,
    output logic                  res_ovf
);

    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};
    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE      = DATA_WIDTH'(1);

    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic [DATA_WIDTH-1:0] quo_reg,   quo_next;
    logic [DATA_WIDTH-1:0] rem_reg,   rem_next;
    logic                  neg_q_reg;
    logic                  neg_r_reg;
    logic                  dz_reg;
    logic                  ovf_reg;
    logic [DATA_WIDTH-1:0] oq_reg,    oq_next;
    logic [DATA_WIDTH-1:0] or_reg,    or_next;
    logic                  oovf_reg;

    logic                  is_signed;
    logic                  d_zero;
    logic [DATA_WIDTH-1:0] nd;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_d;
    logic                  neg_q;
    logic                  neg_r;
    logic                  ovf;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] shifted;

    // operand preparation: zero divisor is taken as one
    always_comb
    begin
        is_signed = (mode == MODE_SIGNED);
        d_zero    = (op_d == '0);
        nd        = d_zero ? ONE : op_d;
        mag_a     = (is_signed && op_a[DATA_WIDTH-1]) ? (~op_a + ONE) : op_a;
        mag_d     = (is_signed && nd[DATA_WIDTH-1]) ? (~nd + ONE) : nd;
        neg_q     = is_signed && (op_a[DATA_WIDTH-1] ^ nd[DATA_WIDTH-1]);
        neg_r     = is_signed && op_a[DATA_WIDTH-1];
        ovf       = d_zero || (is_signed && (op_a == SIGN_BIT) && (op_d == ALL_ONES));
    end

    // one restoring step; a clear top bit of trial means no borrow
    always_comb
    begin
        shifted  = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
        trial    = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, div_reg};
        rem_next = trial[DATA_WIDTH] ? shifted : trial[DATA_WIDTH-1:0];
        quo_next = {quo_reg[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
    end

    // sign fix-up; on divide by zero the remainder is the dividend
    always_comb
    begin
        oq_next = neg_q_reg ? (~quo_reg + ONE) : quo_reg;
        if (dz_reg)
        begin
            or_next = a_reg;
        end
        else
        begin
            or_next = neg_r_reg ? (~rem_reg + ONE) : rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg     <= op_a;
            div_reg   <= mag_d;
            quo_reg   <= mag_a;
            rem_reg   <= '0;
            neg_q_reg <= neg_q;
            neg_r_reg <= neg_r;
            dz_reg    <= d_zero;
            ovf_reg   <= ovf;
        end
        else if (ctl.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctl.finish)
        begin
            oq_reg   <= oq_next;
            or_reg   <= or_next;
            oovf_reg <= ovf_reg;
        end
    end

    assign res_q   = oq_reg;
    assign res_r   = or_reg;
    assign res_ovf = oovf_reg;

endmodule

// ----- src/dwid_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwid_ctrl
// Sequencer for the divider: idle, bit loop, fix-up, output valid.
// ----------------------------------------------------------------------------
module dwid_ctrl
    import dwid_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output dwid_ctl_t ctl
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             ovld_reg,  ovld_next;
    logic             out_free;
    logic             in_xfer;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !ovld_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovld_next  = ovld_reg && out_stall;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // wait here until the output register is free
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign out_valid = ovld_reg;

    a_load_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN) && (cnt_reg == CNT_W'(DATA_WIDTH - 1)))
        else $error("accepted transfer did not start the bit loop");

    a_loop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (cnt_reg == '0) |=> (state_reg == ST_FIX))
        else $error("bit loop did not end after the last step");

    a_finish_safe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> out_free)
        else $error("result overwrote an untaken output");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> ovld_reg && (state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule

// ----- src/double_word_integer_divider.sv -----
// ----------------------------------------------------------------------------
// double_word_integer_divider
// Signed/unsigned truncating divider with remainder and overflow flag.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | cmd, dividend, divisor
//  out     | out_valid / out_stall| quotient, remainder, overflow
//
//  A division runs from input transfer to result as a load, one restoring
//  subtract per quotient bit, and a fix-up that waits for a free output.
//  One division at a time; in_stall is high from the transfer until the
//  result is loaded into the output register.
//  The output register lets a new input transfer in while a result waits.
//  rst_n clears the sequencer and the output valid asynchronously.
// ----------------------------------------------------------------------------
module double_word_integer_divider
    import dwid_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [PORT_W-1:0] dividend,
    input  logic [PORT_W-1:0] divisor,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PORT_W-1:0] quotient,
    output logic [PORT_W-1:0] remainder,
    output logic              overflow
);

    dwid_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] res_q;
    logic [DATA_WIDTH-1:0] res_r;

    dwid_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    dwid_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk     (clk),
        .ctl     (ctl),
        .mode    (cmd),
        .op_a    (dividend[DATA_WIDTH-1:0]),
        .op_d    (divisor[DATA_WIDTH-1:0]),
        .res_q   (res_q),
        .res_r   (res_r),
        .res_ovf (overflow)
    );

    assign quotient  = PORT_W'(res_q);
    assign remainder = PORT_W'(res_r);

endmodule

// ----- tb/sv/double_word_integer_divider_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_word_integer_divider_tb
// Self-checking bench for the signed/unsigned truncating divider. A queue of
// directed corner cases and random divisions feeds a falling-edge driver. A
// rising-edge monitor predicts quotient, remainder and overflow for every
// input transfer and checks each output transfer in order. Both sides idle
// at random, and the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module double_word_integer_divider_tb;
    import dwid_pkg::*;

    localparam int DW        = 64;
    localparam int CALM_LO   = 500;    // no idling on either side in this span
    localparam int CALM_HI   = 600;
    localparam int HOLD_LEN  = 400;
    localparam logic [PORT_W-1:0] MIN_VAL  = {1'b1, {(PORT_W-1){1'b0}}};
    localparam logic [PORT_W-1:0] MAX_VAL  = {1'b0, {(PORT_W-1){1'b1}}};
    localparam logic [PORT_W-1:0] ALL_ONES = {PORT_W{1'b1}};

    typedef struct {
        logic              mode;
        logic [PORT_W-1:0] num;
        logic [PORT_W-1:0] den;
    } div_request_t;

    typedef struct {
        logic [PORT_W-1:0] quo;
        logic [PORT_W-1:0] rem;
        logic              ovf;
    } div_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              cmd       = MODE_SIGNED;
    logic [PORT_W-1:0] dividend  = '0;
    logic [PORT_W-1:0] divisor   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PORT_W-1:0] quotient;
    logic [PORT_W-1:0] remainder;
    logic              overflow;

    div_request_t div_requests[$];
    div_result_t  awaited_results[$];
    logic         in_taken      = 1'b0;
    int           divs_accepted = 0;
    int           mismatches    = 0;
    int           gap_left      = 0;
    int           stall_run     = 0;
    int           hold_left     = 0;
    int           holds_done    = 0;

    double_word_integer_divider #(
        .DATA_WIDTH (DW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quotient  (quotient),
        .remainder (remainder),
        .overflow  (overflow)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Truncating division; a zero divisor counts as one for the quotient only
    function automatic div_result_t divide_truncated(logic mode, logic [PORT_W-1:0] num_in,
                                                     logic [PORT_W-1:0] den_in);
        logic [PORT_W-1:0] mask;
        logic [PORT_W-1:0] sgn;
        logic [PORT_W-1:0] a;
        logic [PORT_W-1:0] d;
        logic [PORT_W-1:0] mag_a;
        logic [PORT_W-1:0] mag_d;
        logic [PORT_W-1:0] q;
        logic              neg;
        div_result_t       res;
        mask  = ALL_ONES >> (PORT_W - DW);
        sgn   = mask ^ (mask >> 1);
        a     = num_in & mask;
        d     = den_in & mask;
        mag_a = a;
        mag_d = d;
        neg   = 1'b0;
        res.ovf = 1'b0;
        if (d == '0)
        begin
            res.ovf = 1'b1;
            mag_d   = PORT_W'(1);
        end
        if (mode == MODE_SIGNED)
        begin
            if ((a & sgn) != '0)
            begin
                neg   = ~neg;
                mag_a = (-a) & mask;
                if (a == sgn && d == mask)
                    res.ovf = 1'b1;
            end
            if ((mag_d & sgn) != '0)
            begin
                neg   = ~neg;
                mag_d = (-mag_d) & mask;
            end
        end
        q = mag_a / mag_d;
        if (neg)
            q = -q;
        q       = q & mask;
        res.quo = q;
        res.rem = (a - q * d) & mask;
        return res;
    endfunction

    function automatic logic [PORT_W-1:0] random_operand();
        logic [PORT_W-1:0] v;
        v = {$urandom(), $urandom()};
        v = v >> $urandom_range(0, PORT_W - 1);
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    task automatic queue_div(logic mode, logic [PORT_W-1:0] num, logic [PORT_W-1:0] den);
        div_request_t req;
        req.mode = mode;
        req.num  = num;
        req.den  = den;
        div_requests.push_back(req);
    endtask

    task automatic report_mismatch(string what, logic [PORT_W-1:0] got,
                                   logic [PORT_W-1:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Sender: holds a stalled payload, idles at random between transfers
    always @(negedge clk)
    begin
        div_request_t req;
        int           pick;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (div_requests.size() != 0)
            begin
                req = div_requests.pop_front();
                in_valid <= 1'b1;
                cmd      <= req.mode;
                dividend <= req.num;
                divisor  <= req.den;
                pick = $urandom_range(0, 99);
                if (divs_accepted >= CALM_LO && divs_accepted < CALM_HI)
                    gap_left <= 0;
                else if (pick < 55)
                    gap_left <= 0;
                else if (pick < 90)
                    gap_left <= $urandom_range(1, 4);
                else
                    gap_left <= $urandom_range(20, 90);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs to back up the input
    always @(negedge clk)
    begin
        int pick;
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if ((holds_done == 0 && divs_accepted >= 300) ||
                     (holds_done == 1 && divs_accepted >= 800))
            begin
                out_stall  <= 1'b1;
                hold_left  <= HOLD_LEN;
                holds_done <= holds_done + 1;
            end
            else if (divs_accepted >= CALM_LO && divs_accepted < CALM_HI)
            begin
                out_stall <= 1'b0;
                stall_run <= 0;
            end
            else if (stall_run != 0)
            begin
                stall_run <= stall_run - 1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    out_stall <= 1'b0;
                    stall_run <= $urandom_range(0, 9);
                end
                else if (pick < 85)
                begin
                    out_stall <= 1'b1;
                    stall_run <= $urandom_range(0, 3);
                end
                else if (pick < 95)
                begin
                    out_stall <= 1'b1;
                    stall_run <= $urandom_range(4, 15);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_run <= $urandom_range(30, 90);
                end
            end
        end
    end

    // Monitor: predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(divide_truncated(cmd, dividend, divisor));
                divs_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with no division pending", quotient, '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (quotient !== want.quo)
                        report_mismatch("quotient", quotient, want.quo);
                    if (remainder !== want.rem)
                        report_mismatch("remainder", remainder, want.rem);
                    if (overflow !== want.ovf)
                        report_mismatch("overflow", PORT_W'(overflow), PORT_W'(want.ovf));
                end
            end
        end
    end

    initial
    begin
        int pick;
        logic [PORT_W-1:0] num;
        logic [PORT_W-1:0] den;

        // signs, truncation, zero divisor, min over -1 and its neighbors
        queue_div(MODE_SIGNED, 64'd7, 64'd2);
        queue_div(MODE_SIGNED, -64'd7, 64'd2);
        queue_div(MODE_SIGNED, 64'd7, -64'd2);
        queue_div(MODE_SIGNED, -64'd7, -64'd2);
        queue_div(MODE_SIGNED, MIN_VAL, ALL_ONES);
        queue_div(MODE_SIGNED, MIN_VAL, 64'd1);
        queue_div(MODE_SIGNED, MIN_VAL, MIN_VAL);
        queue_div(MODE_SIGNED, MAX_VAL, ALL_ONES);
        queue_div(MODE_SIGNED, MAX_VAL, MIN_VAL);
        queue_div(MODE_SIGNED, MAX_VAL, MAX_VAL);
        queue_div(MODE_SIGNED, 64'd5, 64'd0);
        queue_div(MODE_SIGNED, -64'd5, 64'd0);
        queue_div(MODE_SIGNED, 64'd0, 64'd0);
        queue_div(MODE_SIGNED, 64'd0, ALL_ONES);
        queue_div(MODE_SIGNED, 64'd1, MAX_VAL);
        queue_div(MODE_UNSIGNED, ALL_ONES, 64'd1);
        queue_div(MODE_UNSIGNED, ALL_ONES, ALL_ONES);
        queue_div(MODE_UNSIGNED, ALL_ONES, 64'd0);
        queue_div(MODE_UNSIGNED, 64'd0, 64'd0);
        queue_div(MODE_UNSIGNED, MIN_VAL, ALL_ONES);
        queue_div(MODE_UNSIGNED, ALL_ONES, 64'd2);
        queue_div(MODE_UNSIGNED, ALL_ONES, MIN_VAL);
        queue_div(MODE_UNSIGNED, 64'd5, 64'd7);
        queue_div(MODE_UNSIGNED, 64'd100, 64'd10);

        for (int i = 0; i < 1000; i++)
        begin
            pick = $urandom_range(0, 99);
            num  = random_operand();
            den  = random_operand();
            if (pick < 3)
                den = '0;
            else if (pick < 5)
            begin
                num = MIN_VAL;
                den = ALL_ONES;
            end
            else if (pick < 8)
                den = ($urandom_range(0, 1) == 0) ? 64'd1 : ALL_ONES;
            else if (pick < 12)
                num = {$urandom(), $urandom()};
            queue_div($urandom_range(0, 1) ? MODE_UNSIGNED : MODE_SIGNED, num, den);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (div_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * DW + 8) @(posedge clk);

        if (awaited_results.size() != 0)
            report_mismatch("divisions never answered", PORT_W'(awaited_results.size()), '0);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
